@@ design/iterative_dfs_traversal_defines.svh @@
// assertion macros for the depth-first traversal block
`ifndef ITERATIVE_DFS_TRAVERSAL_DEFINES_SVH
`define ITERATIVE_DFS_TRAVERSAL_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define DFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence in the next cycle
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dfs_pkg.sv @@
// shared types, codes and microcode table of the depth-first traversal block
package dfs_pkg;

	// default sizes
	localparam int VERTEX_MAX_DEF  = 32;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int EDGE_POOL_DEF   = 64;

	// fixed field widths
	localparam int KW  = 2;
	localparam int VW  = 5;
	localparam int CW  = 6;
	localparam int DW  = 32;
	localparam int PAW = 3;

	localparam logic [CW-1:0] VCOUNT_RESET = CW'(32);

	// register index
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// item kinds
	localparam logic [KW-1:0] K_CLEAR = 2'd0;
	localparam logic [KW-1:0] K_ADD   = 2'd1;
	localparam logic [KW-1:0] K_START = 2'd2;

	// microprogram steps
	localparam int SW = 4;
	localparam logic [SW-1:0] S_WAIT      = 4'd0;
	localparam logic [SW-1:0] S_CHK_CLR   = 4'd1;
	localparam logic [SW-1:0] S_CHK_ADD   = 4'd2;
	localparam logic [SW-1:0] S_CHK_START = 4'd3;
	localparam logic [SW-1:0] S_START     = 4'd4;
	localparam logic [SW-1:0] S_POP_TEST  = 4'd5;
	localparam logic [SW-1:0] S_POP       = 4'd6;
	localparam logic [SW-1:0] S_LOAD      = 4'd7;
	localparam logic [SW-1:0] S_VISIT     = 4'd8;
	localparam logic [SW-1:0] S_HEAD      = 4'd9;
	localparam logic [SW-1:0] S_EDGE_RD   = 4'd10;
	localparam logic [SW-1:0] S_EDGE_USE  = 4'd11;
	localparam logic [SW-1:0] S_FINISH    = 4'd12;
	localparam logic [SW-1:0] S_CLEAR     = 4'd13;
	localparam logic [SW-1:0] S_ADD_RD    = 4'd14;
	localparam logic [SW-1:0] S_ADD_WR    = 4'd15;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CLEAR,
		OP_ADD_RD,
		OP_ADD_WR,
		OP_START,
		OP_POP,
		OP_LOAD,
		OP_VISIT,
		OP_HEAD,
		OP_EDGE_RD,
		OP_EDGE_USE,
		OP_FLUSH
	} dfs_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_IS_CLEAR,
		C_ADD_OK,
		C_NO_START,
		C_STACK_EMPTY,
		C_LINK_ZERO
	} dfs_cond_t;

	typedef struct packed {
		dfs_op_t        op;
		dfs_cond_t      cond;
		logic [SW-1:0]  target;
	} dfs_uword_t;

	typedef struct packed {
		logic is_clear;
		logic add_ok;
		logic start_ok;
		logic stack_empty;
		logic link_zero;
		logic hold;
	} dfs_flags_t;

	// control store
	function automatic dfs_uword_t dfs_ucode(input logic [SW-1:0] step);
		dfs_uword_t w;
		case (step)
			S_WAIT:      w = '{OP_LATCH,    C_NEXT,        S_WAIT};
			S_CHK_CLR:   w = '{OP_NONE,     C_IS_CLEAR,    S_CLEAR};
			S_CHK_ADD:   w = '{OP_NONE,     C_ADD_OK,      S_ADD_RD};
			S_CHK_START: w = '{OP_NONE,     C_NO_START,    S_WAIT};
			S_START:     w = '{OP_START,    C_NEXT,        S_WAIT};
			S_POP_TEST:  w = '{OP_NONE,     C_STACK_EMPTY, S_FINISH};
			S_POP:       w = '{OP_POP,      C_NEXT,        S_WAIT};
			S_LOAD:      w = '{OP_LOAD,     C_NEXT,        S_WAIT};
			S_VISIT:     w = '{OP_VISIT,    C_NEXT,        S_WAIT};
			S_HEAD:      w = '{OP_HEAD,     C_NEXT,        S_WAIT};
			S_EDGE_RD:   w = '{OP_EDGE_RD,  C_LINK_ZERO,   S_POP_TEST};
			S_EDGE_USE:  w = '{OP_EDGE_USE, C_ALWAYS,      S_EDGE_RD};
			S_FINISH:    w = '{OP_FLUSH,    C_ALWAYS,      S_WAIT};
			S_CLEAR:     w = '{OP_CLEAR,    C_ALWAYS,      S_WAIT};
			S_ADD_RD:    w = '{OP_ADD_RD,   C_NEXT,        S_WAIT};
			S_ADD_WR:    w = '{OP_ADD_WR,   C_ALWAYS,      S_WAIT};
			default:     w = '{OP_LATCH,    C_ALWAYS,      S_WAIT};
		endcase
		return w;
	endfunction

endpackage

@@ design/dfs_ram.sv @@
// generic single-write, single-read ram with registered read data
module dfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/dfs_seq.sv @@
// microprogram sequencer: step counter, control store and conditional jumps
module dfs_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  dfs_pkg::dfs_flags_t flags,
	output dfs_pkg::dfs_uword_t uw
);
	import dfs_pkg::*;

	logic [SW-1:0] step_q;
	logic          take_jump;

	assign uw = dfs_ucode(step_q);

	// jump condition select
	always_comb begin
		case (uw.cond)
			C_NEXT:        take_jump = 1'b0;
			C_ALWAYS:      take_jump = 1'b1;
			C_IS_CLEAR:    take_jump = flags.is_clear;
			C_ADD_OK:      take_jump = flags.add_ok;
			C_NO_START:    take_jump = !flags.start_ok;
			C_STACK_EMPTY: take_jump = flags.stack_empty;
			C_LINK_ZERO:   take_jump = flags.link_zero;
			default:       take_jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else if (!flags.hold) begin
			step_q <= take_jump ? uw.target : step_q + SW'(1);
		end
	end

endmodule

@@ design/iterative_dfs_traversal.sv @@
// top level of the depth-first traversal block over an edge-pool graph
// one item at a time; the input is stalled outside the wait step
// a traversal pops each stack entry, visits its vertex and walks its edge list
// through the edge ram reads; output stalls can hold it
// reset: vertex_count 32, graph empty, marks clear, stack empty; rams are not cleared
`include "iterative_dfs_traversal_defines.svh"

module iterative_dfs_traversal #(
	parameter int VERTEX_MAX  = dfs_pkg::VERTEX_MAX_DEF,
	parameter int STACK_DEPTH = dfs_pkg::STACK_DEPTH_DEF,
	parameter int EDGE_POOL   = dfs_pkg::EDGE_POOL_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [dfs_pkg::PAW-1:0] paddr,
	input  logic [dfs_pkg::DW-1:0]  pwdata,
	output logic [dfs_pkg::DW-1:0]  prdata,
	output logic                    pready,
	// input items
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [dfs_pkg::KW-1:0]  kind,
	input  logic [dfs_pkg::VW-1:0]  src_vertex,
	input  logic [dfs_pkg::VW-1:0]  dest_vertex,
	// result items
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [dfs_pkg::VW-1:0]  visited_vertex,
	output logic                    last
);
	import dfs_pkg::*;

	localparam int VIW = $clog2(VERTEX_MAX);
	localparam int LW  = $clog2(EDGE_POOL + 1);
	localparam int EAW = $clog2(EDGE_POOL);
	localparam int SFW = $clog2(STACK_DEPTH + 1);
	localparam int SAW = $clog2(STACK_DEPTH);

	dfs_uword_t uw;
	dfs_flags_t flags;

	logic [CW-1:0]         vcount_q;
	logic [KW-1:0]         kind_q;
	logic [VW-1:0]         src_q;
	logic [VW-1:0]         dst_q;
	logic [VW-1:0]         cur_q;
	logic [LW-1:0]         link_q;
	logic [LW-1:0]         edges_q;
	logic [SFW-1:0]        fill_q;
	logic [VERTEX_MAX-1:0] seen_q;
	logic [VERTEX_MAX-1:0] head_vld_q;
	logic [VW-1:0]         pend_q;
	logic                  pend_vld_q;
	logic                  out_valid_q;
	logic [VW-1:0]         out_vertex_q;
	logic                  out_last_q;

	logic [VIW-1:0] src_idx, cur_idx, tgt_idx;
	logic           src_ok, dst_ok;
	logic           in_accept, cfg_we;
	logic           need_emit, out_busy, emit_visit, out_load;
	logic           stack_full, push_tgt;
	logic [LW-1:0]  link_dec, head_cur_link, head_src_link, edge_nxt;
	logic [SFW-1:0] fill_dec;
	logic [VW-1:0]  edge_tgt;

	logic           head_we;
	logic [VIW-1:0] head_raddr;
	logic [LW-1:0]  head_wdata, head_rdata;
	logic           edge_we;
	logic [EAW-1:0] edge_waddr, edge_raddr;
	logic [VW+LW-1:0] edge_wdata, edge_rdata;
	logic           stk_we;
	logic [SAW-1:0] stk_waddr, stk_raddr;
	logic [VW-1:0]  stk_wdata, stk_rdata;

	// sequencer
	dfs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[PAW-1] == REG_VERTEX_COUNT);
	assign prdata = (paddr[PAW-1] == REG_VERTEX_COUNT) ? DW'(vcount_q) : '0;

	// range checks against the effective vertex count
	assign src_idx = VIW'(src_q);
	assign cur_idx = VIW'(cur_q);
	assign src_ok  = (32'(src_q) < 32'(vcount_q)) && (32'(src_q) < VERTEX_MAX);
	assign dst_ok  = (32'(dst_q) < 32'(vcount_q)) && (32'(dst_q) < VERTEX_MAX);

	// handshake on the input side
	assign in_stall  = (uw.op != OP_LATCH);
	assign in_accept = in_valid && !in_stall;

	// ram read data decode
	assign head_cur_link = head_vld_q[cur_idx] ? head_rdata : '0;
	assign head_src_link = head_vld_q[src_idx] ? head_rdata : '0;
	assign edge_tgt      = edge_rdata[VW+LW-1:LW];
	assign edge_nxt      = edge_rdata[LW-1:0];
	assign tgt_idx       = VIW'(edge_tgt);
	assign link_dec      = link_q - LW'(1);
	assign fill_dec      = fill_q - SFW'(1);

	// stack and output conditions
	assign stack_full = (32'(fill_q) >= STACK_DEPTH);
	assign push_tgt   = (uw.op == OP_EDGE_USE) && !seen_q[tgt_idx] && !stack_full;
	assign need_emit  = !seen_q[cur_idx];
	assign out_busy   = out_valid_q && out_stall;

	// sequencer flags
	always_comb begin
		flags.is_clear    = (kind_q == K_CLEAR);
		flags.add_ok      = (kind_q == K_ADD) && src_ok && dst_ok &&
		                    (32'(edges_q) < EDGE_POOL);
		flags.start_ok    = (kind_q == K_START) && src_ok;
		flags.stack_empty = (fill_q == '0);
		flags.link_zero   = (link_q == '0);
		case (uw.op)
			OP_LATCH: flags.hold = !in_valid;
			OP_VISIT: flags.hold = need_emit && pend_vld_q && out_busy;
			OP_FLUSH: flags.hold = pend_vld_q && out_busy;
			default:  flags.hold = 1'b0;
		endcase
	end

	assign emit_visit = (uw.op == OP_VISIT) && need_emit && !flags.hold;
	assign out_load   = (emit_visit && pend_vld_q) ||
	                    ((uw.op == OP_FLUSH) && pend_vld_q && !flags.hold);

	// list head ram
	assign head_we    = (uw.op == OP_ADD_WR);
	assign head_wdata = edges_q + LW'(1);
	assign head_raddr = (uw.op == OP_ADD_RD) ? src_idx : cur_idx;

	dfs_ram #(.WIDTH(LW), .DEPTH(VERTEX_MAX)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (src_idx),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// edge pool ram: target and link
	assign edge_we    = (uw.op == OP_ADD_WR);
	assign edge_waddr = edges_q[EAW-1:0];
	assign edge_wdata = {dst_q, head_src_link};
	assign edge_raddr = link_dec[EAW-1:0];

	dfs_ram #(.WIDTH(VW + LW), .DEPTH(EDGE_POOL)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	// walk stack ram
	assign stk_we    = (uw.op == OP_START) || push_tgt;
	assign stk_waddr = (uw.op == OP_START) ? '0 : fill_q[SAW-1:0];
	assign stk_wdata = (uw.op == OP_START) ? src_q : edge_tgt;
	assign stk_raddr = fill_dec[SAW-1:0];

	dfs_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RESET;
			edges_q     <= '0;
			fill_q      <= '0;
			seen_q      <= '0;
			head_vld_q  <= '0;
			pend_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= pwdata[CW-1:0];
			end
			case (uw.op)
				OP_CLEAR: begin
					head_vld_q <= '0;
					seen_q     <= '0;
					edges_q    <= '0;
				end
				OP_ADD_WR: begin
					head_vld_q[src_idx] <= 1'b1;
					edges_q             <= edges_q + LW'(1);
				end
				OP_START: begin
					seen_q <= '0;
					fill_q <= SFW'(1);
				end
				OP_POP: begin
					fill_q <= fill_dec;
				end
				OP_VISIT: begin
					if (emit_visit) begin
						seen_q[cur_idx] <= 1'b1;
						pend_vld_q      <= 1'b1;
					end
				end
				OP_EDGE_USE: begin
					if (push_tgt) begin
						fill_q <= fill_q + SFW'(1);
					end
				end
				OP_FLUSH: begin
					if (!flags.hold) begin
						pend_vld_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q <= kind;
			src_q  <= src_vertex;
			dst_q  <= dest_vertex;
		end
		if (uw.op == OP_LOAD) begin
			cur_q <= stk_rdata;
		end
		if (uw.op == OP_HEAD) begin
			link_q <= head_cur_link;
		end else if (uw.op == OP_EDGE_USE) begin
			link_q <= edge_nxt;
		end
		if (emit_visit) begin
			pend_q <= cur_q;
		end
		if (out_load) begin
			out_vertex_q <= pend_q;
			out_last_q   <= (uw.op == OP_FLUSH);
		end
	end

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign last           = out_last_q;

	// checks
	`DFS_ASSERT_ALWAYS(a_fill_bound, 32'(fill_q) <= STACK_DEPTH, "stack fill beyond depth")
	`DFS_ASSERT_IMPL(a_pop_nonempty, uw.op == OP_POP, fill_q != '0, "pop from empty stack")
	`DFS_ASSERT_IMPL(a_wait_no_pend, uw.op == OP_LATCH, !pend_vld_q, "result left pending at wait")
	`DFS_ASSERT_NEXT(a_visit_marks, emit_visit, seen_q[$past(cur_idx)], "visited vertex not marked")

endmodule
